/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted
`define JSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds across reset
`define JSU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/jsu_pkg.sv */
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helper functions for the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

    // Width of the per-string byte counter
    localparam int COUNT_BITS = 16;
    // Width used for the capacity compare (covers counter and register)
    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    // Largest counter value, extended to the compare width
    localparam logic [LIM_W-1:0] CMAX_EXT = LIM_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [15:0] CAP_RESET = 16'd256;

    // Queue depth between front and back
    localparam int QD   = 2;
    localparam int QA_W = (QD > 1) ? $clog2(QD) : 1;

    // Characters that matter to the decoder
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Surrogate ranges
    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PARSE_ERR = 2'd1,
        ST_TOO_SMALL = 2'd2
    } t_status;

    // Up to four UTF-8 bytes, b[0] goes out first
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } t_seq;

    // One classified item: its bytes and, on the final character, a status
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
        logic            eos;
        t_status         status;
    } t_pkt;

    // Hex digit value; bit 4 flags a non-hex character
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // UTF-8 encoding of a code point (up to 21 bits)
    function automatic t_seq utf8_enc(input logic [20:0] cp);
        t_seq s;
        s.b = '0;
        if (cp < 21'h80) begin
            s.n    = 3'd1;
            s.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            s.n    = 3'd2;
            s.b[0] = 8'hC0 | {3'b000, cp[10:6]};
            s.b[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp < 21'h10000) begin
            s.n    = 3'd3;
            s.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            s.b[1] = 8'h80 | {2'b00, cp[11:6]};
            s.b[2] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            s.n    = 3'd4;
            s.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            s.b[1] = 8'h80 | {2'b00, cp[17:12]};
            s.b[2] = 8'h80 | {2'b00, cp[11:6]};
            s.b[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return s;
    endfunction

endpackage

/* src/jsu_front.sv */
// ---------------------------------------------------------------------------
// jsu_front
// Accepts raw characters, runs the escape decoder and capacity check, and
// hands one packet per productive character to the queue.
// ---------------------------------------------------------------------------
module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_char,
    input  logic              i_end_of_string,
    input  logic              i_q_full,
    output logic              o_push,
    output jsu_pkg::t_pkt     o_pkt
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        M_PLAIN   = 6'b000001,
        M_ESC     = 6'b000010,
        M_HEX_HI  = 6'b000100,
        M_WANT_BS = 6'b001000,
        M_WANT_U  = 6'b010000,
        M_HEX_LO  = 6'b100000
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [15:0]           r_hex, n_hex;
    logic [9:0]            r_hi, n_hi;
    logic [1:0]            r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_bw, n_bw;
    logic                  r_ovf, n_ovf;
    logic                  r_err, n_err;
    logic [15:0]           r_cap;

    logic                  accept;
    logic [4:0]            dv;
    logic [15:0]           hex_new;
    logic                  raw_vld;
    logic [7:0]            raw_byte;
    logic                  cp_vld;
    logic [20:0]           cp;
    t_seq                  enc;
    t_seq                  seq;
    logic [LIM_W-1:0]      cap_ext;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W:0]        sum;
    logic [2:0]            emit_n;
    logic                  err_final;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign dv      = hex_val(i_in_char);
    assign hex_new = {r_hex[11:0], dv[3:0]};

    // Escape decoder
    always_comb begin
        n_mode   = r_mode;
        n_hex    = r_hex;
        n_hi     = r_hi;
        n_cnt    = r_cnt;
        n_err    = r_err;
        raw_vld  = 1'b0;
        raw_byte = i_in_char;
        cp_vld   = 1'b0;
        cp       = {5'd0, hex_new};
        if (!r_err) begin
            unique case (r_mode)
                M_PLAIN: begin
                    if (i_in_char == CH_BSL) begin
                        n_mode = M_ESC;
                    end else begin
                        raw_vld = 1'b1;
                    end
                end
                M_ESC: begin
                    n_mode = M_PLAIN;
                    unique case (i_in_char) inside
                        CH_QUOTE, CH_BSL, CH_SLASH: raw_vld = 1'b1;
                        CH_B: begin raw_vld = 1'b1; raw_byte = 8'h08; end
                        CH_F: begin raw_vld = 1'b1; raw_byte = 8'h0C; end
                        CH_N: begin raw_vld = 1'b1; raw_byte = 8'h0A; end
                        CH_R: begin raw_vld = 1'b1; raw_byte = 8'h0D; end
                        CH_T: begin raw_vld = 1'b1; raw_byte = 8'h09; end
                        CH_U: begin
                            n_mode = M_HEX_HI;
                            n_hex  = '0;
                            n_cnt  = '0;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
                M_HEX_HI, M_HEX_LO: begin
                    if (dv[4]) begin
                        n_err = 1'b1;
                    end else if (r_cnt != 2'd3) begin
                        n_hex = hex_new;
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_hex = hex_new;
                        n_cnt = '0;
                        if (r_mode == M_HEX_HI) begin
                            if (hex_new >= HI_SUR_MIN && hex_new <= HI_SUR_MAX) begin
                                // low 10 bits of D800 are zero
                                n_hi   = hex_new[9:0];
                                n_mode = M_WANT_BS;
                            end else if (hex_new >= LO_SUR_MIN && hex_new <= LO_SUR_MAX) begin
                                n_err = 1'b1;
                            end else begin
                                n_mode = M_PLAIN;
                                cp_vld = 1'b1;
                            end
                        end else begin
                            if (hex_new >= LO_SUR_MIN && hex_new <= LO_SUR_MAX) begin
                                n_mode = M_PLAIN;
                                cp_vld = 1'b1;
                                cp     = SUPP_BASE + {1'b0, r_hi, hex_new[9:0]};
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                end
                M_WANT_BS: begin
                    if (i_in_char == CH_BSL) n_mode = M_WANT_U;
                    else                     n_err  = 1'b1;
                end
                M_WANT_U: begin
                    if (i_in_char == CH_U) begin
                        n_mode = M_HEX_LO;
                        n_hex  = '0;
                        n_cnt  = '0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase
            if (n_err) n_mode = M_PLAIN;
        end
    end

    // Byte sequence from this character
    assign enc = utf8_enc(cp);
    always_comb begin
        seq = enc;
        if (raw_vld) begin
            seq.n    = 3'd1;
            seq.b    = '0;
            seq.b[0] = raw_byte;
        end
    end

    // Capacity check: a sequence that does not fit is dropped whole
    assign cap_ext = LIM_W'(r_cap);
    assign limit   = (cap_ext < CMAX_EXT) ? cap_ext : CMAX_EXT;
    assign sum     = (LIM_W + 1)'(r_bw) + (LIM_W + 1)'(seq.n);

    always_comb begin
        n_bw   = r_bw;
        n_ovf  = r_ovf;
        emit_n = '0;
        if ((raw_vld || cp_vld) && !r_ovf) begin
            if (sum > {1'b0, limit}) begin
                n_ovf = 1'b1;
            end else begin
                n_bw   = sum[COUNT_BITS-1:0];
                emit_n = seq.n;
            end
        end
    end

    // Status on the final character; an open escape counts as a parse error
    assign err_final = n_err || (n_mode != M_PLAIN);

    always_comb begin
        o_pkt.n   = emit_n;
        o_pkt.b   = seq.b;
        o_pkt.eos = i_end_of_string;
        if (err_final)  o_pkt.status = ST_PARSE_ERR;
        else if (n_ovf) o_pkt.status = ST_TOO_SMALL;
        else            o_pkt.status = ST_OK;
    end

    assign o_push = accept && ((emit_n != 3'd0) || i_end_of_string);

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_PLAIN;
            r_hex  <= '0;
            r_hi   <= '0;
            r_cnt  <= '0;
            r_bw   <= '0;
            r_ovf  <= 1'b0;
            r_err  <= 1'b0;
        end else if (accept) begin
            if (i_end_of_string) begin
                r_mode <= M_PLAIN;
                r_hex  <= '0;
                r_hi   <= '0;
                r_cnt  <= '0;
                r_bw   <= '0;
                r_ovf  <= 1'b0;
                r_err  <= 1'b0;
            end else begin
                r_mode <= n_mode;
                r_hex  <= n_hex;
                r_hi   <= n_hi;
                r_cnt  <= n_cnt;
                r_bw   <= n_bw;
                r_ovf  <= n_ovf;
                r_err  <= n_err;
            end
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

endmodule

/* src/jsu_queue.sv */
// ---------------------------------------------------------------------------
// jsu_queue
// Short packet queue between the decoder front and the result back end.
// ---------------------------------------------------------------------------
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_pkt i_pkt,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_vld,
    output jsu_pkg::t_pkt o_head
);
    import jsu_pkg::*;

    t_pkt            r_mem [QD];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full     = (r_cnt == (QA_W + 1)'(QD));
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pkt;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == QA_W'(QD - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == QA_W'(QD - 1)) ? '0 : r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* src/jsu_back.sv */
// ---------------------------------------------------------------------------
// jsu_back
// Walks the head packet one result per cycle into the output register while i_out_ready is high.
// ---------------------------------------------------------------------------
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_vld,
    input  jsu_pkg::t_pkt i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_char,
    output logic          o_char_valid,
    output logic          o_done_res,
    output logic [1:0]    o_status,
    output logic          o_last_result
);
    import jsu_pkg::*;

    logic [2:0] r_idx;
    logic       r_ovld;
    logic [7:0] r_char;
    logic       r_cv;
    logic       r_done;
    t_status    r_status;
    logic       r_last;

    logic       load;
    logic       is_byte;
    logic       pkt_end;

    assign load    = i_head_vld && (!r_ovld || i_out_ready);
    assign is_byte = (r_idx < i_head.n);
    // The packet ends on its last byte, or on the status result at end of string
    assign pkt_end = !is_byte || ((r_idx + 3'd1 == i_head.n) && !i_head.eos);
    assign o_pop   = load && pkt_end;

    // Result index within the head packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= pkt_end ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char   <= is_byte ? i_head.b[r_idx[1:0]] : 8'h00;
            r_cv     <= is_byte;
            r_done   <= !is_byte;
            r_status <= is_byte ? ST_OK : i_head.status;
            r_last   <= pkt_end;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_out_char    = r_char;
    assign o_char_valid  = r_cv;
    assign o_done_res    = r_done;
    assign o_status      = r_status;
    assign o_last_result = r_last;

endmodule

/* src/json_string_unescape_utf8.sv */
// ---------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper producing UTF-8 bytes and a per-string status.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one raw body character per
//   transfer, with i_end_of_string on the final one. Output channel
//   (o_out_valid / i_out_ready) delivers results: 0..4 byte results per
//   character, then one status result (o_done_res) on the final character.
//   o_last_result marks the last result caused by each character; a
//   character that causes nothing gives no result.
//   Capacity is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// Dataflow:
//   The first result of a character passes through the packet queue and the
//   output register. The back end emits one result per cycle while i_out_ready
//   is high, so the results of one character leave one after another;
//   characters with at most one result stream at one per cycle. A two-entry
//   packet queue lets the decoder keep taking input while the back end drains.
// Reset and stall:
//   Reset (synchronous) empties the queue and output register, clears the
//   decoder state and sets capacity to 256. When i_out_ready is low the
//   output holds, the queue fills and o_in_ready drops.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic        o_last_result
);
    import jsu_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic head_vld;
    t_pkt pkt_in;
    t_pkt head;

    // Decoder front
    jsu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_char       (i_in_char),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_pkt           (pkt_in)
    );

    // Packet queue
    jsu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pkt      (pkt_in),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_head_vld (head_vld),
        .o_head     (head)
    );

    // Result back end
    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_vld    (head_vld),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

endmodule

/* src/jsu_checker.sv */
// ---------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_char,
    input logic        o_char_valid,
    input logic        o_done_res,
    input logic [1:0]  o_status,
    input logic        o_last_result
);
    import jsu_pkg::*;

    logic char_zero;

    assign char_zero = (o_out_char == 8'h00);

    // Reset empties the output
    `JSU_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A held result is not withdrawn
    `JSU_ASSERT(a_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped in stall")

    // Every result is either a byte or a status
    `JSU_ASSERT(a_kind, o_out_valid |-> (o_char_valid != o_done_res), "bad result kind")

    // A status result closes its character and carries no byte
    `JSU_ASSERT(a_done, o_out_valid && o_done_res |-> o_last_result && char_zero, "bad status")

    // Byte results carry status ok
    `JSU_ASSERT(a_byte, o_out_valid && o_char_valid |-> (o_status == ST_OK), "status on byte")

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (.*);

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for json_string_unescape_utf8. A queue of raw string
// characters feeds a bursty sender; a stalling receiver takes the results.
// Every character transfer runs through a local unescape/UTF-8 predictor
// and every result transfer is compared field by field with its prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import jsu_pkg::*;

    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [2:0] {
        DM_PLAIN, DM_ESC, DM_HEX_HI, DM_WANT_BSL, DM_WANT_U, DM_HEX_LO
    } t_dec_mode;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_style;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_char_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       done;
        t_status    st;
        logic       last;
    } t_decoded;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_char = '0;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_char_valid;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic        o_last_result;

    // Predictor state, mirrors the decoder
    logic [15:0] cap_copy = CAP_RESET;
    t_dec_mode   dmode = DM_PLAIN;
    logic [15:0] hex_acc = '0;
    logic [9:0]  hi_half = '0;
    logic [1:0]  ndigits = '0;
    int          nbytes = 0;
    logic        overflowed = 1'b0;
    logic        parse_err = 1'b0;
    logic [7:0]  staged_bytes[$];
    t_decoded    decoded_q[$];

    // Stimulus
    t_char_item  char_queue[$];
    logic [7:0]  str_buf[$];
    logic [7:0]  esc_letters[8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    t_char_item  next_item;
    int          burst_left = 0;
    int          gap_left = 0;
    int          gap_pick;

    // Receiver
    t_rx_style   rx_style = RX_FREE;
    logic [31:0] rx_cycle = '0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;

    // Bookkeeping
    int          fail_count = 0;
    int          results_checked = 0;
    int          strings_sent = 0;
    int          chars_sent = 0;
    int          status_seen[3] = '{0, 0, 0};

    json_string_unescape_utf8 DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_char      (i_in_char),
        .i_end_of_string(i_end_of_string),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if (c >= 8'h61 && c <= 8'h66) return {1'b0, c[3:0] + 4'd9};
        if (c >= 8'h41 && c <= 8'h46) return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic void restart_string();
        dmode      = DM_PLAIN;
        hex_acc    = '0;
        hi_half    = '0;
        ndigits    = '0;
        nbytes     = 0;
        overflowed = 1'b0;
        parse_err  = 1'b0;
    endfunction

    function automatic void flag_parse_error();
        parse_err = 1'b1;
        dmode     = DM_PLAIN;
    endfunction

    // A sequence goes out whole or not at all; once dropped, nothing more
    function automatic void put_seq(input logic [3:0][7:0] seq, input int n);
        if (overflowed || parse_err) return;
        if (nbytes + n > int'(cap_copy)) begin
            overflowed = 1'b1;
            return;
        end
        for (int i = 0; i < n; i++) staged_bytes.push_back(seq[i]);
        nbytes += n;
    endfunction

    function automatic void put_code_point(input logic [20:0] cp);
        logic [3:0][7:0] s;
        s = '0;
        if (cp < 21'h80) begin
            s[0] = cp[7:0];
            put_seq(s, 1);
        end else if (cp < 21'h800) begin
            s[0] = {3'b110, cp[10:6]};
            s[1] = {2'b10, cp[5:0]};
            put_seq(s, 2);
        end else if (cp < 21'h10000) begin
            s[0] = {4'b1110, cp[15:12]};
            s[1] = {2'b10, cp[11:6]};
            s[2] = {2'b10, cp[5:0]};
            put_seq(s, 3);
        end else begin
            s[0] = {5'b11110, cp[20:18]};
            s[1] = {2'b10, cp[17:12]};
            s[2] = {2'b10, cp[11:6]};
            s[3] = {2'b10, cp[5:0]};
            put_seq(s, 4);
        end
    endfunction

    // One character in, its byte results and, at end of string, the closing status queued
    function automatic void unescape_char(input logic [7:0] c, input logic e);
        logic [3:0][7:0] s;
        logic [4:0]      nib;
        logic [15:0]     code;
        t_status         st;
        int              n;
        s = '0;
        staged_bytes.delete();
        if (!parse_err) begin
            case (dmode)
                DM_PLAIN: begin
                    if (c == CH_BSL) begin
                        dmode = DM_ESC;
                    end else begin
                        s[0] = c;
                        put_seq(s, 1);
                    end
                end
                DM_ESC: begin
                    dmode = DM_PLAIN;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: s[0] = c;
                        CH_B: s[0] = 8'h08;
                        CH_F: s[0] = 8'h0C;
                        CH_N: s[0] = 8'h0A;
                        CH_R: s[0] = 8'h0D;
                        CH_T: s[0] = 8'h09;
                        CH_U: begin
                            dmode   = DM_HEX_HI;
                            hex_acc = '0;
                            ndigits = '0;
                        end
                        default: flag_parse_error();
                    endcase
                    if (dmode == DM_PLAIN && !parse_err) put_seq(s, 1);
                end
                DM_HEX_HI, DM_HEX_LO: begin
                    nib = hex_nibble(c);
                    if (nib[4]) begin
                        flag_parse_error();
                    end else begin
                        hex_acc = {hex_acc[11:0], nib[3:0]};
                        if (ndigits != 2'd3) begin
                            ndigits = ndigits + 2'd1;
                        end else begin
                            ndigits = '0;
                            code    = hex_acc;
                            if (dmode == DM_HEX_HI) begin
                                if (code >= HI_SUR_MIN && code <= HI_SUR_MAX) begin
                                    hi_half = code[9:0];
                                    dmode   = DM_WANT_BSL;
                                end else if (code >= LO_SUR_MIN && code <= LO_SUR_MAX) begin
                                    flag_parse_error();
                                end else begin
                                    dmode = DM_PLAIN;
                                    put_code_point({5'b0, code});
                                end
                            end else if (code >= LO_SUR_MIN && code <= LO_SUR_MAX) begin
                                dmode = DM_PLAIN;
                                put_code_point(SUPP_BASE + {1'b0, hi_half, code[9:0]});
                            end else begin
                                flag_parse_error();
                            end
                        end
                    end
                end
                DM_WANT_BSL: begin
                    if (c == CH_BSL) dmode = DM_WANT_U;
                    else flag_parse_error();
                end
                DM_WANT_U: begin
                    if (c == CH_U) begin
                        dmode   = DM_HEX_LO;
                        hex_acc = '0;
                        ndigits = '0;
                    end else begin
                        flag_parse_error();
                    end
                end
                default: flag_parse_error();
            endcase
        end
        n = staged_bytes.size();
        for (int k = 0; k < n; k++)
            decoded_q.push_back(t_decoded'{staged_bytes[k], 1'b1, 1'b0, ST_OK,
                                           logic'(!e && k == n - 1)});
        // closing status: an open escape at the end counts as a parse error
        if (e) begin
            if (!parse_err && dmode != DM_PLAIN) parse_err = 1'b1;
            if (parse_err) st = ST_PARSE_ERR;
            else if (overflowed) st = ST_TOO_SMALL;
            else st = ST_OK;
            decoded_q.push_back(t_decoded'{8'h00, 1'b0, 1'b1, st, 1'b1});
            restart_string();
        end
    endfunction

    // ---------------------------------------------------------------------
    // String builders
    // ---------------------------------------------------------------------
    function automatic void commit_string();
        foreach (str_buf[i])
            char_queue.push_back(t_char_item'{str_buf[i], logic'(i == str_buf.size() - 1)});
        chars_sent += str_buf.size();
        strings_sent++;
        str_buf.delete();
    endfunction

    function automatic void add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) str_buf.push_back(txt[i]);
    endfunction

    // Four hex digits, letters in random case
    function automatic void add_hex4(input logic [15:0] v);
        logic [3:0] d;
        for (int i = 3; i >= 0; i--) begin
            d = v[i*4 +: 4];
            if (d < 4'd10) str_buf.push_back(8'h30 + d);
            else if ($urandom_range(0, 1) != 0) str_buf.push_back(8'h41 + d - 8'd10);
            else str_buf.push_back(8'h61 + d - 8'd10);
        end
    endfunction

    function automatic void add_u_escape(input logic [15:0] v);
        str_buf.push_back(CH_BSL);
        str_buf.push_back(CH_U);
        add_hex4(v);
    endfunction

    // Non-surrogate BMP code point spread over 1, 2 and 3 byte encodings
    function automatic logic [15:0] bmp_code();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            default: begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= HI_SUR_MIN && v <= LO_SUR_MAX) v = v ^ 16'h2000;
            end
        endcase
        return v;
    endfunction

    // Mostly well-formed strings; some carry one broken escape.
    // Returns the number of characters queued.
    function automatic int add_random_string();
        int         pieces;
        int         bad_at;
        int         counted;
        int         r;
        bit         cut;
        bit         known;
        logic [7:0] c;
        logic [4:0] nib;
        pieces  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        bad_at  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pieces - 1) : -1;
        cut     = 1'b0;
        for (int p = 0; p < pieces && !cut; p++) begin
            if (p == bad_at) begin
                case ($urandom_range(0, 6))
                    0: begin
                        // escape letter that is not defined
                        str_buf.push_back(CH_BSL);
                        do begin
                            c = 8'($urandom_range(0, 255));
                            known = (c == CH_U);
                            foreach (esc_letters[i]) if (c == esc_letters[i]) known = 1'b1;
                        end while (known);
                        str_buf.push_back(c);
                    end
                    1: begin
                        // non-hex character among the digits
                        str_buf.push_back(CH_BSL);
                        str_buf.push_back(CH_U);
                        repeat ($urandom_range(0, 3))
                            str_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
                        do begin
                            c   = 8'($urandom_range(0, 255));
                            nib = hex_nibble(c);
                        end while (!nib[4]);
                        str_buf.push_back(c);
                    end
                    2: add_u_escape(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
                    3: begin
                        // high half followed by something other than a backslash
                        add_u_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
                        do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
                        str_buf.push_back(c);
                    end
                    4: begin
                        add_u_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
                        str_buf.push_back(CH_BSL);
                        do c = 8'($urandom_range(0, 255)); while (c == CH_U);
                        str_buf.push_back(c);
                    end
                    5: begin
                        // high half, then a \u that is not a low half
                        add_u_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
                        if ($urandom_range(0, 1) != 0) add_u_escape(bmp_code());
                        else add_u_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
                    end
                    default: begin
                        // string ends in the middle of an escape
                        str_buf.push_back(CH_BSL);
                        r = $urandom_range(0, 3);
                        if (r == 3) begin
                            str_buf.push_back(CH_U);
                            add_hex4(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
                            r = $urandom_range(0, 2);
                            if (r > 0) str_buf.push_back(CH_BSL);
                            if (r > 1) begin
                                str_buf.push_back(CH_U);
                                repeat ($urandom_range(0, 3))
                                    str_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
                            end
                        end else if (r > 0) begin
                            str_buf.push_back(CH_U);
                            repeat ($urandom_range(0, 3))
                                str_buf.push_back(8'h61 + 8'($urandom_range(0, 5)));
                        end
                        cut = 1'b1;
                    end
                endcase
            end else begin
                r = $urandom_range(0, 19);
                if (r < 8) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
                    str_buf.push_back(c);
                end else if (r < 12) begin
                    str_buf.push_back(CH_BSL);
                    str_buf.push_back(esc_letters[$urandom_range(0, 7)]);
                end else if (r < 16) begin
                    add_u_escape(bmp_code());
                end else begin
                    add_u_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
                    add_u_escape(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
                end
            end
        end
        counted = str_buf.size();
        commit_string();
        return counted;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: bursts of transfers with random gaps
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid      <= 1'b0;
            i_in_char       <= '0;
            i_end_of_string <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end else begin
            if (i_in_valid && o_in_ready) unescape_char(i_in_char, i_end_of_string);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (char_queue.size() != 0) begin
                    next_item        = char_queue.pop_front();
                    i_in_valid      <= 1'b1;
                    i_in_char       <= next_item.ch;
                    i_end_of_string <= next_item.eos;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_pick    = $urandom_range(0, 7);
                        if (gap_pick < 3) gap_left <= 0;
                        else if (gap_pick == 7) gap_left <= $urandom_range(10, 24);
                        else gap_left <= $urandom_range(1, 4);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stall style redrawn at random when rx_cycle[6:0] wraps to zero; long hold on request
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_FREE:  i_out_ready <= 1'b1;
                RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:  i_out_ready <= (rx_cycle[2:0] < 3'd3);
            endcase
        end
        if (rx_cycle[6:0] == 7'd0) rx_style <= t_rx_style'($urandom_range(0, 3));
    end

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %b %b %0d %b",
                         $time, o_out_char, o_char_valid, o_done_res, o_status, o_last_result);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_char", want.ch, o_out_char);
                check_field("char_valid", want.cv, o_char_valid);
                check_field("done_res", want.done, o_done_res);
                check_field("status", want.st, o_status);
                check_field("last_result", want.last, o_last_result);
                results_checked++;
                if (want.done) status_seen[want.st]++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    task automatic wait_idle();
        @(negedge i_clk);
        while (char_queue.size() != 0 || i_in_valid || decoded_q.size() != 0)
            @(negedge i_clk);
        // characters with no result may still be inside the block
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cap_copy       = v;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] cap, input int n_chars, input bit long_stall);
        int queued;
        wait_idle();
        write_capacity(cap);
        queued = 0;
        while (queued < n_chars) queued += add_random_string();
        // receiver holds off while the sender keeps offering
        if (long_stall) begin
            @(posedge i_clk);
            hold_req <= hold_req + 1;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings at the reset capacity
        str_buf = '{8'h00, 8'hFF};
        commit_string();
        add_text("\\t");
        commit_string();
        add_text("\\u20ac");
        commit_string();
        add_text("\\uD83D\\uDE00");
        commit_string();
        add_text("\\q");
        commit_string();
        str_buf.push_back(CH_BSL);
        commit_string();

        run_phase(16'hFFFF, 80, 1'b1);
        run_phase(16'd1, 30, 1'b0);
        run_phase(16'($urandom_range(2, 12)), 70, 1'b0);
        run_phase(16'd0, 10, 1'b0);
        run_phase(16'($urandom_range(13, 400)), 90, 1'b1);
        wait_idle();

        $display("summary: %0d characters in %0d strings, %0d results checked",
                 chars_sent, strings_sent, results_checked);
        $display("summary: status ok %0d, parse error %0d, too small %0d; capacity 0 to 65535",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
src/jsu_checker.sv
verif/tb_top.sv
